// ===== design/twtt_pkg.sv =====
// Package for the tag whitelist toggle table: sequencer states, command and
// status codes, fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twtt_pkg;

   localparam int TAG_W    = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 5;

   // Command codes (req command field)
   localparam logic CMD_TOGGLE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd5;

   typedef enum logic [1:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DECIDE
   } seq_state_type;

endpackage

`default_nettype wire

// ===== design/twtt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module twtt_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/tag_whitelist_toggle_table.sv =====
// Top level of the tag whitelist toggle table: sequencer, scan compare unit
// and result register. Uses twtt_pkg and the twtt_ram tag store.
//
//   channel  dir  handshake            payload (low bit up)
//   req      in   req_tvalid/tready    tdata: command[0], tag[32:1], zero fill
//   rsp      out  rsp_tvalid/tready    tdata: status[2:0], slot_index[7:3]
//
// After reset the tag store is zeroed one slot a cycle;
// req_tready stays low until that pass ends. Reset is synchronous, active high.
// A nonzero tag is worked in steps: one read per slot through the single RAM
// read port, one compare per slot, a final decide/write step. A zero tag goes
// straight from accept to decide. One item is worked at a time; the result
// register frees the sequencer once loaded, so a stalled rsp only holds the
// decide state of the following item.
`timescale 1ns / 1ps
`default_nettype none

module tag_whitelist_toggle_table
   import twtt_pkg::*;
#(
   parameter int TABLE_SLOTS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // command[0], tag[32:1], zero[39:33]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // status[2:0], slot_index[7:3]
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

   // Sequencer state
   seq_state_type state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;         // read / clear address
   logic             issue_done_ff, issue_done_in;
   logic             rd_valid_ff, rd_valid_in; // RAM output holds a slot
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;   // slot on the RAM output

   // Item being worked
   logic             cmd_ff, cmd_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   // RAM port signals
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [TAG_W-1:0] wr_data;
   logic [TAG_W-1:0] rd_data;

   logic [IDX_W-1:0]        res_idx;
   logic [IDX_W+SLOT_W-1:0] res_idx_wide;

   logic             req_tag_zero;
   logic             match, empty;

   twtt_ram #(
      .WIDTH  (TAG_W),
      .DEPTH  (TABLE_SLOTS),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_tag_zero = (req_tdata[32:1] == '0);
   assign match = rd_valid_ff && (rd_data == tag_ff);
   assign empty = rd_valid_ff && (rd_data == '0);

   // Only the low 5 bits of the slot number are reported
   assign res_idx_wide = {{SLOT_W{1'b0}}, res_idx};

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      rd_valid_in   = 1'b0;
      rd_addr_in    = addr_ff;
      cmd_in        = cmd_ff;
      tag_in        = tag_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      status_in     = status_ff;
      slot_in       = slot_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;
      req_tready    = 1'b0;
      res_idx       = '0;

      case (state_ff)
         SEQ_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_SLOT) begin
               addr_in  = '0;
               state_in = SEQ_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in        = req_tdata[0];
               tag_in        = req_tdata[32:1];
               addr_in       = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               hit_idx_in    = '0;
               free_idx_in   = '0;
               state_in      = req_tag_zero ? SEQ_DECIDE : SEQ_SCAN;
            end
         end

         SEQ_SCAN: begin
            // issue side: one slot read per cycle
            if (!issue_done_ff) begin
               rd_valid_in = 1'b1;
               rd_addr_in  = addr_ff;
               if (addr_ff == LAST_SLOT) begin
                  issue_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            // compare side: keep lowest match and lowest empty slot
            if (match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_addr_ff;
            end
            if (empty && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_addr_ff;
            end
            if (rd_valid_ff && rd_addr_ff == LAST_SLOT) begin
               state_in = SEQ_DECIDE;
            end
         end

         SEQ_DECIDE: begin
            if (tag_ff == '0) begin
               status_in = STAT_ZERO;
            end else if (cmd_ff == CMD_TOGGLE) begin
               if (hit_ff) begin
                  status_in = STAT_REMOVED;
                  res_idx   = hit_idx_ff;
               end else if (free_ff) begin
                  status_in = STAT_ADDED;
                  res_idx   = free_idx_ff;
               end else begin
                  status_in = STAT_FULL;
               end
            end else begin
               if (hit_ff) begin
                  status_in = STAT_FOUND;
                  res_idx   = hit_idx_ff;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
            end
            slot_in = res_idx_wide[SLOT_W-1:0];

            // wait for the result register to free up before committing
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
               if (tag_ff != '0 && cmd_ff == CMD_TOGGLE && (hit_ff || free_ff)) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
                  wr_data = hit_ff ? '0 : tag_ff;
               end
            end else begin
               status_in = status_ff;
               slot_in   = slot_ff;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_CLEAR;
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      cmd_ff      <= cmd_in;
      tag_ff      <= tag_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {slot_ff, status_ff};

endmodule

`default_nettype wire
